FILE: hw/rtl/tcae_pkg.sv
// Shared types and constants for the tree common ancestor engine.
// Used by the controller, the datapath and the top level; no dependencies.
package tcae_pkg;

	// Tree size and lifting depth.
	localparam int NODE_COUNT  = 1024;
	localparam int NODE_W      = 10;
	localparam int LEVEL_COUNT = 10;
	localparam int LEVEL_W     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int DEPTH_W     = 10;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	// The ancestor table is addressed by {node, level}.
	localparam int ANC_ADDR_W  = NODE_W + LEVEL_W;
	localparam int ANC_ENTRIES = NODE_COUNT << LEVEL_W;

	// Transaction kinds on the mode input.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_ROOT,
		ST_LD_RD,
		ST_LD_WR,
		ST_LD_DWR,
		ST_Q_DRD,
		ST_Q_ORDER,
		ST_Q_LIFT,
		ST_Q_LWR,
		ST_Q_CHK,
		ST_Q_JRD,
		ST_Q_JWR,
		ST_Q_FRD,
		ST_Q_FOUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the input transaction
		logic ld_root;   // write level 0 of the row, start the row walk
		logic ld_rd;     // read the walked ancestor at the previous level
		logic ld_wr;     // write the next level of the row
		logic dep_wr;    // write the depth of the loaded node
		logic q_order;   // put the deeper node first and form the difference
		logic lift_wr;   // lift the first node by one level
		logic lvl_dec;   // step to the next lower level
		logic jump_init; // restart the level count for the joint climb
		logic jump_wr;   // climb both nodes where their ancestors differ
		logic emit_u;    // return the first node
		logic emit_rd;   // return the ancestor just read
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic same;      // both working nodes are equal
		logic lvl_zero;  // level counter is at zero
		logic lvl_last;  // level counter is at the top level
		logic diff_bit;  // depth difference bit at the current level
	} status_t;

endpackage

FILE: hw/rtl/tcae_datapath.sv
// Datapath of the tree common ancestor engine: ancestor and depth memories,
// working node registers, level counter and the result register. Uses tcae_pkg.
module tcae_datapath
	import tcae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [NODE_W-1:0] first_node,
	input  logic [NODE_W-1:0] second_node,
	output status_t           status,
	output logic [NODE_W-1:0] ancestor,
	output logic              done
);

	logic [NODE_W-1:0]      anc_mem [ANC_ENTRIES];
	logic [DEPTH_W-1:0]     dep_mem [NODE_COUNT];

	logic [NODE_W-1:0]      u_q;
	logic [NODE_W-1:0]      v_q;
	logic [NODE_W-1:0]      cur_q;
	logic [LEVEL_W-1:0]     lvl_q;
	logic [LEVEL_COUNT-1:0] diff_q;

	logic [NODE_W-1:0]      anc_a_raw_q;
	logic [NODE_W-1:0]      anc_b_raw_q;
	logic                   anc_a_zero_q;
	logic                   anc_b_zero_q;
	logic [DEPTH_W-1:0]     dep_a_raw_q;
	logic [DEPTH_W-1:0]     dep_b_raw_q;
	logic                   dep_a_zero_q;
	logic                   dep_b_zero_q;

	logic [NODE_W-1:0]      ancestor_q;
	logic                   done_q;

	logic [NODE_W-1:0]      rd_node_a;
	logic [LEVEL_W-1:0]     rd_lvl_a;
	logic [NODE_W-1:0]      anc_a;
	logic [NODE_W-1:0]      anc_b;
	logic [DEPTH_W-1:0]     dep_a;
	logic [DEPTH_W-1:0]     dep_b;
	logic                   anc_we;
	logic [ANC_ADDR_W-1:0]  anc_waddr;
	logic [NODE_W-1:0]      anc_wdata;
	logic                   dep_we;
	logic [DEPTH_W-1:0]     dep_wdata;
	logic [DEPTH_W-1:0]     dep_big;
	logic [DEPTH_W-1:0]     dep_small;

	// Read port A follows the row walk during a load, else the first node.
	always_comb begin
		if (cmd.ld_rd) begin
			rd_node_a = cur_q;
			rd_lvl_a  = lvl_q - LEVEL_W'(1);
		end else begin
			rd_node_a = u_q;
			rd_lvl_a  = lvl_q;
		end
	end

	// Registered reads; node 0 is tracked so that it reads as all zero.
	always_ff @(posedge clk) begin
		anc_a_raw_q  <= anc_mem[{rd_node_a, rd_lvl_a}];
		anc_b_raw_q  <= anc_mem[{v_q, lvl_q}];
		anc_a_zero_q <= (rd_node_a == '0);
		anc_b_zero_q <= (v_q == '0);
		dep_a_raw_q  <= dep_mem[u_q];
		dep_b_raw_q  <= dep_mem[v_q];
		dep_a_zero_q <= (u_q == '0);
		dep_b_zero_q <= (v_q == '0);
	end

	assign anc_a = anc_a_zero_q ? '0 : anc_a_raw_q;
	assign anc_b = anc_b_zero_q ? '0 : anc_b_raw_q;
	assign dep_a = dep_a_zero_q ? '0 : dep_a_raw_q;
	assign dep_b = dep_b_zero_q ? '0 : dep_b_raw_q;

	// Row and depth writes for a load; node 0 is never written.
	always_comb begin
		anc_we    = (cmd.ld_root || cmd.ld_wr) && (u_q != '0);
		anc_waddr = cmd.ld_root ? {u_q, LEVEL_W'(0)} : {u_q, lvl_q};
		anc_wdata = cmd.ld_root ? v_q : anc_a;
		dep_we    = cmd.dep_wr && (u_q != '0);
		if (v_q == '0) begin
			dep_wdata = '0;
		end else if (dep_b == DEPTH_MAX) begin
			dep_wdata = DEPTH_MAX;
		end else begin
			dep_wdata = dep_b + DEPTH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_waddr] <= anc_wdata;
		end
		if (dep_we) begin
			dep_mem[u_q] <= dep_wdata;
		end
	end

	// Ordering of the two query depths.
	always_comb begin
		if (dep_b > dep_a) begin
			dep_big   = dep_b;
			dep_small = dep_a;
		end else begin
			dep_big   = dep_a;
			dep_small = dep_b;
		end
	end

	// Working node registers, row walk pointer, level count and difference.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			u_q <= first_node;
			v_q <= second_node;
		end else if (cmd.q_order) begin
			if (dep_b > dep_a) begin
				u_q <= v_q;
				v_q <= u_q;
			end
		end else if (cmd.lift_wr) begin
			u_q <= anc_a;
		end else if (cmd.jump_wr) begin
			if (anc_a != anc_b) begin
				u_q <= anc_a;
				v_q <= anc_b;
			end
		end

		if (cmd.ld_root) begin
			cur_q <= v_q;
		end else if (cmd.ld_wr) begin
			cur_q <= anc_a;
		end

		if (cmd.ld_root) begin
			lvl_q <= LEVEL_W'(1);
		end else if (cmd.ld_wr) begin
			lvl_q <= lvl_q + LEVEL_W'(1);
		end else if (cmd.q_order || cmd.jump_init) begin
			lvl_q <= LEVEL_W'(LEVEL_COUNT - 1);
		end else if (cmd.lvl_dec) begin
			lvl_q <= lvl_q - LEVEL_W'(1);
		end

		if (cmd.q_order) begin
			diff_q <= LEVEL_COUNT'(dep_big - dep_small);
		end
	end

	// Result register and its one-cycle strobe.
	always_ff @(posedge clk) begin
		if (cmd.emit_u) begin
			ancestor_q <= u_q;
		end else if (cmd.emit_rd) begin
			ancestor_q <= anc_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_u || cmd.emit_rd;
		end
	end

	assign status.same     = (u_q == v_q);
	assign status.lvl_zero = (lvl_q == '0);
	assign status.lvl_last = (lvl_q == LEVEL_W'(LEVEL_COUNT - 1));
	assign status.diff_bit = diff_q[lvl_q];

	assign ancestor = ancestor_q;
	assign done     = done_q;

endmodule

FILE: hw/rtl/tcae_controller.sv
// Controller state machine of the tree common ancestor engine.
// Sequences loads and queries through the datapath; uses tcae_pkg.
module tcae_controller
	import tcae_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    mode,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = (mode == MODE_QUERY) ? ST_Q_DRD : ST_LD_ROOT;
				end
			end
			ST_LD_ROOT: begin
				cmd.ld_root = 1'b1;
				state_next  = (LEVEL_COUNT == 1) ? ST_LD_DWR : ST_LD_RD;
			end
			ST_LD_RD: begin
				cmd.ld_rd  = 1'b1;
				state_next = ST_LD_WR;
			end
			ST_LD_WR: begin
				cmd.ld_wr  = 1'b1;
				state_next = status.lvl_last ? ST_LD_DWR : ST_LD_RD;
			end
			ST_LD_DWR: begin
				cmd.dep_wr = 1'b1;
				state_next = ST_IDLE;
			end
			ST_Q_DRD: begin
				// The depth reads are in flight; equal nodes answer at once.
				if (status.same) begin
					cmd.emit_u = 1'b1;
					state_next = ST_IDLE;
				end else begin
					state_next = ST_Q_ORDER;
				end
			end
			ST_Q_ORDER: begin
				cmd.q_order = 1'b1;
				state_next  = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				// Read only at levels where the difference has a one.
				if (status.diff_bit) begin
					state_next = ST_Q_LWR;
				end else if (status.lvl_zero) begin
					state_next = ST_Q_CHK;
				end else begin
					cmd.lvl_dec = 1'b1;
				end
			end
			ST_Q_LWR: begin
				cmd.lift_wr = 1'b1;
				if (status.lvl_zero) begin
					state_next = ST_Q_CHK;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_next  = ST_Q_LIFT;
				end
			end
			ST_Q_CHK: begin
				if (status.same) begin
					cmd.emit_u = 1'b1;
					state_next = ST_IDLE;
				end else begin
					cmd.jump_init = 1'b1;
					state_next    = ST_Q_JRD;
				end
			end
			ST_Q_JRD: begin
				state_next = ST_Q_JWR;
			end
			ST_Q_JWR: begin
				cmd.jump_wr = 1'b1;
				if (status.lvl_zero) begin
					state_next = ST_Q_FRD;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_next  = ST_Q_JRD;
				end
			end
			ST_Q_FRD: begin
				// The level count is zero here, so the read gives the parent.
				state_next = ST_Q_FOUT;
			end
			ST_Q_FOUT: begin
				cmd.emit_rd = 1'b1;
				state_next  = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/tree_common_ancestor_engine.sv
// Lowest common ancestor engine over a binary-lifting table, one transaction at a time.
// A load writes the node's ancestor row level by level, with one ancestor-table read per level.
// A query answers equal nodes at once; otherwise its length is set by one registered table
// read per lifting step, and the result strobe is registered from the final state.
// The result is shown for one cycle on done and cannot be stalled.
// Reset clears the controller and the strobe only; table entries are valid once loaded.
module tree_common_ancestor_engine
	import tcae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [NODE_W-1:0] first_node,
	input  logic [NODE_W-1:0] second_node,
	output logic [NODE_W-1:0] ancestor,
	output logic              done
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	tcae_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Tables, working registers and result register.
	tcae_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.first_node  (first_node),
		.second_node (second_node),
		.status      (status),
		.ancestor    (ancestor),
		.done        (done)
	);

	// An accepted transaction always occupies the engine in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not make the engine busy");

	// A result is produced only at the end of a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe without a finishing transaction");

	// Each query gives a single result strobe.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

FILE: tb/tcae_lca_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tree common ancestor engine. It mirrors the ancestor rows and node
// depths, predicts the common ancestor of each query and compares it with the done strobe.
// Depends on tcae_pkg for widths, store sizes and transaction kinds.
module tcae_lca_checker
	import tcae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              mode,
	input  logic [NODE_W-1:0] first_node,
	input  logic [NODE_W-1:0] second_node,
	input  logic [NODE_W-1:0] ancestor,
	input  logic              done,
	output int                mismatches,
	output int                pending,
	output int                loads_seen,
	output int                queries_seen
);

	// Mirror of the lifting table and the depth store.
	logic [NODE_W-1:0]  lift_rows   [NODE_COUNT][LEVEL_COUNT];
	logic [DEPTH_W-1:0] node_depths [NODE_COUNT];

	// Common ancestors still owed by the block, oldest first.
	logic [NODE_W-1:0]  lca_expected [$];
	logic [NODE_W-1:0]  lca_want;

	int mismatch_count = 0;
	int pending_count  = 0;
	int load_count     = 0;
	int result_count   = 0;

	assign mismatches   = mismatch_count;
	assign pending      = pending_count;
	assign loads_seen   = load_count;
	assign queries_seen = result_count;

	// Node 0 keeps an all-zero row and depth zero for the whole run.
	initial begin
		for (int n = 0; n < NODE_COUNT; n++) begin
			node_depths[n] = '0;
			for (int j = 0; j < LEVEL_COUNT; j++)
				lift_rows[n][j] = '0;
		end
	end

	// A load fills the node's row level by level from the rows above it.
	task automatic record_load(input logic [NODE_W-1:0] node, input logic [NODE_W-1:0] parent);
		logic [DEPTH_W-1:0] parent_depth;
		if (node == '0)
			return;
		parent_depth = node_depths[parent];
		lift_rows[node][0] = parent;
		for (int j = 1; j < LEVEL_COUNT; j++)
			lift_rows[node][j] = lift_rows[lift_rows[node][j-1]][j-1];
		if (parent == '0)
			node_depths[node] = '0;
		else
			node_depths[node] = (parent_depth == DEPTH_MAX) ? DEPTH_MAX :
				parent_depth + DEPTH_W'(1);
	endtask

	// Lift the deeper node to the other's depth, then climb both while their ancestors differ.
	function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		logic [NODE_W-1:0]  u;
		logic [NODE_W-1:0]  v;
		logic [NODE_W-1:0]  t;
		logic [NODE_W-1:0]  up_u;
		logic [NODE_W-1:0]  up_v;
		logic [DEPTH_W-1:0] gap;
		if (a == b)
			return a;
		u = a;
		v = b;
		if (node_depths[v] > node_depths[u]) begin
			t = u;
			u = v;
			v = t;
		end
		gap = node_depths[u] - node_depths[v];
		for (int i = LEVEL_COUNT - 1; i >= 0; i--)
			if (gap[i])
				u = lift_rows[u][i];
		if (u == v)
			return u;
		for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
			up_u = lift_rows[u][i];
			up_v = lift_rows[v][i];
			if (up_u != up_v) begin
				u = up_u;
				v = up_v;
			end
		end
		return lift_rows[u][0];
	endfunction

	// Results are checked before a transaction accepted at the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (lca_expected.size() == 0) begin
					mismatch_count++;
					$display("%0t: ancestor with no query waiting: expected none, actual %0d",
						$time, ancestor);
				end else begin
					lca_want = lca_expected.pop_front();
					if (ancestor !== lca_want) begin
						mismatch_count++;
						$display("%0t: ancestor mismatch: expected %0d, actual %0d",
							$time, lca_want, ancestor);
					end
				end
			end
			if (start && !busy) begin
				if (mode == MODE_QUERY) begin
					lca_expected = {lca_expected, common_ancestor(first_node, second_node)};
				end else begin
					record_load(first_node, second_node);
					load_count++;
				end
			end
			pending_count = lca_expected.size();
		end
	end

endmodule

FILE: tb/tb_tree_common_ancestor_engine.sv
`timescale 1ns / 1ps
// Testbench top for the tree common ancestor engine: clock, reset, load and query stimulus.
// Depends on tcae_pkg, the engine itself and the tcae_lca_checker scoreboard.
module tb_tree_common_ancestor_engine;
	import tcae_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 50;
	localparam int RANDOM_ITEMS = 765;
	localparam int CYCLE_LOADS  = 48;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              mode        = MODE_LOAD;
	logic [NODE_W-1:0] first_node  = '0;
	logic [NODE_W-1:0] second_node = '0;
	logic              busy;
	logic              done;
	logic [NODE_W-1:0] ancestor;

	int mismatches;
	int pending;
	int loads_seen;
	int queries_seen;
	int cycle_count = 0;
	int idle_pct    = 0;

	// Nodes whose rows have been written; apart from node 0, the random part queries and uses as parents only these.
	bit                is_loaded [NODE_COUNT];
	logic [NODE_W-1:0] loaded_nodes [$];

	tree_common_ancestor_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.first_node  (first_node),
		.second_node (second_node),
		.ancestor    (ancestor),
		.done        (done)
	);

	tcae_lca_checker lca_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.first_node   (first_node),
		.second_node  (second_node),
		.ancestor     (ancestor),
		.done         (done),
		.mismatches   (mismatches),
		.pending      (pending),
		.loads_seen   (loads_seen),
		.queries_seen (queries_seen)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one transaction from a falling edge and hold it until busy is low at a rising edge.
	task automatic issue(input logic kind, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		mode        <= kind;
		first_node  <= a;
		second_node <= b;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic load_node(input logic [NODE_W-1:0] node, input logic [NODE_W-1:0] parent);
		issue(MODE_LOAD, node, parent);
		if (!is_loaded[node]) begin
			is_loaded[node] = 1'b1;
			loaded_nodes = {loaded_nodes, node};
		end
	endtask

	function automatic logic [NODE_W-1:0] any_loaded();
		return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
	endfunction

	// Recently loaded nodes tend to sit deep, which exercises the higher lifting levels.
	function automatic logic [NODE_W-1:0] recent_loaded();
		int lo;
		lo = (loaded_nodes.size() > 8) ? loaded_nodes.size() - 8 : 0;
		return loaded_nodes[$urandom_range(lo, loaded_nodes.size() - 1)];
	endfunction

	// Mostly fresh nodes hung under deep parents; now and then a reload, a root or a cycle.
	task automatic random_load();
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] parent;
		int                pick;
		int                tries;
		node  = '0;
		tries = 0;
		if ($urandom_range(0, 99) < 85) begin
			while (node == '0 && tries < 16) begin
				node = NODE_W'($urandom_range(1, NODE_COUNT - 1));
				if (is_loaded[node])
					node = '0;
				tries++;
			end
		end
		if (node == '0)
			node = any_loaded();
		pick = $urandom_range(0, 99);
		if (pick < 6)
			parent = '0;
		else if (pick < 36)
			parent = loaded_nodes[loaded_nodes.size() - 1];
		else if (pick < 76)
			parent = recent_loaded();
		else
			parent = any_loaded();
		if (parent == node && $urandom_range(0, 9) != 0)
			parent = any_loaded();
		load_node(node, parent);
	endtask

	task automatic random_query();
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		int                pick;
		a    = ($urandom_range(0, 1) == 0) ? any_loaded() : recent_loaded();
		pick = $urandom_range(0, 99);
		if (pick < 5)
			b = '0;
		else if (pick < 10)
			b = a;
		else if (pick < 40)
			b = recent_loaded();
		else
			b = any_loaded();
		issue(MODE_QUERY, a, b);
	endtask

	task automatic random_item();
		if ($urandom_range(0, 99) < 35)
			random_load();
		else
			random_query();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: a small forest with the field extremes.
		load_node(10'd1, 10'd0);
		load_node(10'd1023, 10'd1);
		load_node(10'd512, 10'd1023);
		load_node(10'd2, 10'd0);
		load_node(10'd3, 10'd2);
		load_node(10'd682, 10'd3);
		load_node(10'd341, 10'd682);
		issue(MODE_QUERY, 10'd1023, 10'd1);
		issue(MODE_QUERY, 10'd1, 10'd512);
		issue(MODE_QUERY, 10'd341, 10'd512);
		issue(MODE_QUERY, 10'd341, 10'd0);
		issue(MODE_QUERY, 10'd1023, 10'd1023);
		// The same node twice needs no table read, so even a node never loaded is legal.
		issue(MODE_QUERY, 10'd1000, 10'd1000);
		issue(MODE_QUERY, 10'd682, 10'd341);
		issue(MODE_QUERY, 10'd512, 10'd1023);
		// A node reloaded as its own parent leaves its children with stale rows.
		load_node(10'd3, 10'd3);
		issue(MODE_QUERY, 10'd341, 10'd3);
		issue(MODE_QUERY, 10'd3, 10'd2);
		load_node(10'd4, 10'd341);
		issue(MODE_QUERY, 10'd4, 10'd1);
		issue(MODE_QUERY, 10'd4, 10'd682);

		// Random part under three sender idle rates.
		idle_pct = 32;
		repeat (RANDOM_ITEMS / 3) random_item();
		idle_pct = 77;
		repeat (RANDOM_ITEMS / 3) random_item();
		idle_pct = 0;
		repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) random_item();

		// Two nodes reloaded as each other's parent, so their depths keep growing.
		load_node(10'd1021, 10'd0);
		for (int k = 0; k < CYCLE_LOADS / 2; k++) begin
			load_node(10'd1022, 10'd1021);
			load_node(10'd1021, 10'd1022);
		end
		issue(MODE_QUERY, 10'd1022, 10'd1021);
		repeat (16)
			issue(MODE_QUERY, any_loaded(),
				($urandom_range(0, 1) == 0) ? 10'd1021 : 10'd1022);
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d loads and %0d query results over three idle rates,", loads_seen,
			queries_seen);
		$display("including forests, self-parent reloads, node zero and long parent cycles.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
